FILE: design/rope_rh_pkg.sv
// shared types, constants and the scale/saturate function for the rotate-half
// rotary embedding block; no dependencies
package rope_rh_pkg;

  localparam int MAX_HALF_DEF = 64;
  localparam int MAX_ROW_DEF  = 1024;

  localparam int DATA_W     = 16;
  localparam int IDX_W      = 10;
  localparam int DIMS_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_DIMS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COPY_TAIL = 1'd1;

  localparam logic [DIMS_W-1:0] ROT_DIMS_RST  = 8'd128;
  localparam logic              COPY_TAIL_RST = 1'b1;

  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic [IDX_W-1:0]           index_t;
  typedef logic signed [2*DATA_W-1:0] prod_t;
  typedef logic signed [2*DATA_W:0]   sum_t;

  typedef enum logic {
    KIND_PASS,
    KIND_PAIR
  } kind_t;

  typedef struct packed {
    data_t x0;
    data_t c0;
    data_t s0;
  } held_t;

  typedef struct packed {
    kind_t  kind;
    data_t  x;
    data_t  c;
    data_t  s;
    index_t idx_lo;
    index_t idx_hi;
    logic   last;
  } item_t;

  // floor shift by 15, then saturate to 16 bits
  function automatic data_t scale_sat(input sum_t v);
    logic signed [DATA_W+1:0] q;
    data_t r;
    q = (DATA_W+2)'(v >>> (DATA_W-1));
    if (q[DATA_W+1:DATA_W-1] == '0 || q[DATA_W+1:DATA_W-1] == '1) begin
      r = q[DATA_W-1:0];
    end else if (q[DATA_W+1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: design/rope_rh_in_if.sv
// input channel: one row element with its cos and sin
// depends on rope_rh_pkg
interface rope_rh_in_if;
  logic               valid;
  logic               ready;
  rope_rh_pkg::data_t element_value;
  rope_rh_pkg::data_t cos_value;
  rope_rh_pkg::data_t sin_value;
  logic               row_end;

  modport source(output valid, element_value, cos_value, sin_value, row_end, input ready);
  modport sink(input valid, element_value, cos_value, sin_value, row_end, output ready);
endinterface

FILE: design/rope_rh_out_if.sv
// output channel: one rotated or passed-through element
// depends on rope_rh_pkg
interface rope_rh_out_if;
  logic                valid;
  logic                ready;
  rope_rh_pkg::data_t  result_value;
  rope_rh_pkg::index_t result_index;
  logic                result_last;

  modport source(output valid, result_value, result_index, result_last, input ready);
  modport sink(input valid, result_value, result_index, result_last, output ready);
endinterface

FILE: design/rope_rh_store.sv
// first-half element store: one write port, one read port, registered read
// depends on rope_rh_pkg
module rope_rh_store #(
  parameter int DEPTH = rope_rh_pkg::MAX_HALF_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  rope_rh_pkg::held_t  wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output rope_rh_pkg::held_t  rdata
);

  rope_rh_pkg::held_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rope_rh_rotate.sv
// rotation datapath: product stage, then sum/saturate into output register
// depends on rope_rh_pkg and rope_rh_out_if
module rope_rh_rotate (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  rope_rh_pkg::item_t  s1_item,
  input  rope_rh_pkg::held_t  held,
  output logic                s1_adv,
  rope_rh_out_if.source       res
);

  logic                s2_valid;
  rope_rh_pkg::kind_t  s2_kind;
  rope_rh_pkg::prod_t  s2_pa1;
  rope_rh_pkg::prod_t  s2_pa2;
  rope_rh_pkg::prod_t  s2_pb1;
  rope_rh_pkg::prod_t  s2_pb2;
  rope_rh_pkg::data_t  s2_x;
  rope_rh_pkg::index_t s2_idx_lo;
  rope_rh_pkg::index_t s2_idx_hi;
  logic                s2_last;
  logic                s2_adv;

  logic                s3_valid;
  logic                s3_pair;
  logic                s3_sel;
  rope_rh_pkg::data_t  s3_v0;
  rope_rh_pkg::data_t  s3_v1;
  rope_rh_pkg::index_t s3_idx_lo;
  rope_rh_pkg::index_t s3_idx_hi;
  logic                s3_last;
  logic                s3_done;

  rope_rh_pkg::sum_t   sum_a;
  rope_rh_pkg::sum_t   sum_b;

  assign s3_done = res.ready && (!s3_pair || s3_sel);
  assign s2_adv  = !s3_valid || s3_done;
  assign s1_adv  = !s2_valid || s2_adv;

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      s2_kind   <= s1_item.kind;
      s2_pa1    <= rope_rh_pkg::prod_t'(held.c0) * rope_rh_pkg::prod_t'(held.x0);
      s2_pa2    <= rope_rh_pkg::prod_t'(held.s0) * rope_rh_pkg::prod_t'(s1_item.x);
      s2_pb1    <= rope_rh_pkg::prod_t'(s1_item.c) * rope_rh_pkg::prod_t'(s1_item.x);
      s2_pb2    <= rope_rh_pkg::prod_t'(s1_item.s) * rope_rh_pkg::prod_t'(held.x0);
      s2_x      <= s1_item.x;
      s2_idx_lo <= s1_item.idx_lo;
      s2_idx_hi <= s1_item.idx_hi;
      s2_last   <= s1_item.last;
    end
  end

  // sums, then scale and saturate into the output register
  assign sum_a = rope_rh_pkg::sum_t'(s2_pa1) - rope_rh_pkg::sum_t'(s2_pa2);
  assign sum_b = rope_rh_pkg::sum_t'(s2_pb1) + rope_rh_pkg::sum_t'(s2_pb2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_sel   <= 1'b0;
    end else if (s2_adv) begin
      s3_valid <= s2_valid;
      s3_sel   <= 1'b0;
    end else if (res.valid && res.ready) begin
      s3_sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      s3_pair   <= (s2_kind == rope_rh_pkg::KIND_PAIR);
      s3_v0     <= rope_rh_pkg::scale_sat(sum_a);
      s3_v1     <= (s2_kind == rope_rh_pkg::KIND_PAIR) ? rope_rh_pkg::scale_sat(sum_b) : s2_x;
      s3_idx_lo <= s2_idx_lo;
      s3_idx_hi <= s2_idx_hi;
      s3_last   <= s2_last;
    end
  end

  // first of a pair goes out before the second
  assign res.valid        = s3_valid;
  assign res.result_value = (s3_pair && !s3_sel) ? s3_v0 : s3_v1;
  assign res.result_index = (s3_pair && !s3_sel) ? s3_idx_lo : s3_idx_hi;
  assign res.result_last  = s3_last && (!s3_pair || s3_sel);

  a_pair_second: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && s3_pair && !s3_sel |=> res.valid && s3_sel)
    else $error("second result of a pair did not follow");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && s3_pair && !s3_sel |-> !res.result_last)
    else $error("last marker on first result of a pair");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_adv |=> s2_valid && $stable(s2_pa1) && $stable(s2_idx_hi))
    else $error("stalled product stage changed");

endmodule

FILE: design/rotary_embedding_rotate_half_core.sv
// rotate-half rotary embedding core: top level with config, element count,
// first-half store and rotation datapath; depends on rope_rh_pkg, the channel
// interfaces, rope_rh_store and rope_rh_rotate
// first result passes through stage 1, the product stage and the output register
// throughput: one element per cycle while out_ch is ready; a second-half element holds the output for its two results
// reset (synchronous): count and stage valids cleared, rot_dims 128, copy_tail 1
module rotary_embedding_rotate_half_core #(
  parameter int MAX_HALF = rope_rh_pkg::MAX_HALF_DEF,
  parameter int MAX_ROW  = rope_rh_pkg::MAX_ROW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  rope_rh_in_if.sink                          in_ch,
  rope_rh_out_if.source                       out_ch,
  input  logic                                cfg_write,
  input  logic [rope_rh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rope_rh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW   = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
  localparam int CW   = $clog2(MAX_ROW);
  localparam int CMPW = (CW > 10) ? CW : 10;

  logic [rope_rh_pkg::DIMS_W-1:0] rot_dims;
  logic                           copy_tail;
  logic [CW-1:0]                  element_count;
  logic [CW-1:0]                  element_count_next;

  logic [8:0]      half_raw;
  logic [8:0]      half;
  logic [9:0]      rdims;
  logic [CMPW-1:0] cur;
  logic [CMPW-1:0] j;
  logic            in_first;
  logic            in_second;
  logic            accept;
  logic            in_ready;

  logic                s1_valid;
  logic                s1_adv;
  rope_rh_pkg::item_t  s1_item;
  rope_rh_pkg::held_t  held_wdata;
  rope_rh_pkg::held_t  held_rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_dims  <= rope_rh_pkg::ROT_DIMS_RST;
      copy_tail <= rope_rh_pkg::COPY_TAIL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rope_rh_pkg::REG_ROT_DIMS:  rot_dims  <= cfg_data;
        rope_rh_pkg::REG_COPY_TAIL: copy_tail <= cfg_data[0];
      endcase
    end
  end

  // classify the element by its index in the row
  always_comb begin
    half_raw  = {2'b00, rot_dims[rope_rh_pkg::DIMS_W-1:1]};
    half      = (half_raw > 9'(MAX_HALF)) ? 9'(MAX_HALF) : half_raw;
    rdims     = {half, 1'b0};
    cur       = CMPW'(element_count);
    in_first  = cur < CMPW'(half);
    in_second = !in_first && (cur < CMPW'(rdims));
    j         = cur - CMPW'(half);
  end

  assign in_ready    = !s1_valid || s1_adv;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  always_comb begin
    if (in_ch.row_end || element_count == CW'(MAX_ROW - 1)) begin
      element_count_next = '0;
    end else begin
      element_count_next = element_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (accept) begin
      element_count <= element_count_next;
    end
  end

  // stage 1: item registered alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && (in_second || (!in_first && copy_tail));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.kind   <= in_second ? rope_rh_pkg::KIND_PAIR : rope_rh_pkg::KIND_PASS;
      s1_item.x      <= in_ch.element_value;
      s1_item.c      <= in_ch.cos_value;
      s1_item.s      <= in_ch.sin_value;
      s1_item.idx_lo <= rope_rh_pkg::IDX_W'(j);
      s1_item.idx_hi <= rope_rh_pkg::IDX_W'(element_count);
      s1_item.last   <= in_ch.row_end;
    end
  end

  assign held_wdata.x0 = in_ch.element_value;
  assign held_wdata.c0 = in_ch.cos_value;
  assign held_wdata.s0 = in_ch.sin_value;

  rope_rh_store #(
    .DEPTH (MAX_HALF)
  ) u_store (
    .clk   (clk),
    .we    (accept && in_first),
    .waddr (AW'(element_count)),
    .wdata (held_wdata),
    .re    (accept && in_second),
    .raddr (AW'(j)),
    .rdata (held_rdata)
  );

  rope_rh_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .held     (held_rdata),
    .s1_adv   (s1_adv),
    .res      (out_ch)
  );

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.row_end |=> element_count == '0)
    else $error("element count not cleared after row end");

  a_partner_range: assert property (@(posedge clk) disable iff (rst)
    accept && in_second |-> j < CMPW'(half))
    else $error("partner address out of range");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item) && $stable(held_rdata))
    else $error("stalled stage 1 changed");

endmodule
